// ===== rtl/wspd_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the window stack, pointer hit test and drag block.
package wspd_pkg;

   // Configuration register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_SCREEN_WIDTH  = 2'd0,
      REG_SCREEN_HEIGHT = 2'd1,
      REG_TITLE_HEIGHT  = 2'd2,
      REG_BORDER_WIDTH  = 2'd3
   } reg_index_type;

   localparam logic [12:0] SCREEN_WIDTH_RESET  = 13'd1024;
   localparam logic [12:0] SCREEN_HEIGHT_RESET = 13'd768;
   localparam logic [7:0]  TITLE_HEIGHT_RESET  = 8'd26;
   localparam logic [3:0]  BORDER_WIDTH_RESET  = 4'd2;
   localparam logic [11:0] LIMIT_X_RESET       = 12'd1022;
   localparam logic [11:0] LIMIT_Y_RESET       = 12'd766;
   localparam logic [11:0] POINTER_X_RESET     = 12'd512;
   localparam logic [11:0] POINTER_Y_RESET     = 12'd384;

   localparam int REQ_W = 80;

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] top;
      logic [11:0] width;
      logic [11:0] height;
   } rect_type;

   typedef struct packed {
      logic load;
      logic take_above;
      logic take_below;
      logic drag_wr;
   } cell_ctl_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_RAISE,
      ST_DRAG,
      ST_RESULT
   } state_type;

endpackage

// ===== rtl/wspd_cell.sv =====
`timescale 1ns / 1ps
// One stack position: holds a window rectangle and its slot, hit-tests it, swaps with neighbors.
module wspd_cell #(
   parameter int SLOT_W = 3
) (
   input  logic                  clock,
   input  wspd_pkg::cell_ctl_type ctl,
   input  logic [SLOT_W-1:0]     load_slot,
   input  wspd_pkg::rect_type    load_rect,
   input  logic [SLOT_W-1:0]     above_slot,
   input  wspd_pkg::rect_type    above_rect,
   input  logic [SLOT_W-1:0]     below_slot,
   input  wspd_pkg::rect_type    below_rect,
   input  logic [15:0]           drag_left,
   input  logic [15:0]           drag_top,
   input  logic [11:0]           px,
   input  logic [11:0]           py,
   input  logic [3:0]            border,
   output logic [SLOT_W-1:0]     slot,
   output wspd_pkg::rect_type    rect,
   output logic                  hit
);

   logic [SLOT_W-1:0]  slot_ff;
   wspd_pkg::rect_type rect_ff;

   logic signed [18:0] lo_x, hi_x, lo_y, hi_y, px_s, py_s, bw_s;

   always_ff @(posedge clock) begin
      priority if (ctl.load) begin
         slot_ff <= load_slot;
         rect_ff <= load_rect;
      end else if (ctl.take_above) begin
         slot_ff <= above_slot;
         rect_ff <= above_rect;
      end else if (ctl.take_below) begin
         slot_ff <= below_slot;
         rect_ff <= below_rect;
      end else if (ctl.drag_wr) begin
         rect_ff.left <= drag_left;
         rect_ff.top  <= drag_top;
      end
   end

   // rectangle grown by the border on all sides, right and bottom edges exclusive
   always_comb begin
      bw_s = $signed({15'd0, border});
      px_s = $signed({7'd0, px});
      py_s = $signed({7'd0, py});
      lo_x = $signed({{3{rect_ff.left[15]}}, rect_ff.left}) - bw_s;
      hi_x = $signed({{3{rect_ff.left[15]}}, rect_ff.left}) + $signed({7'd0, rect_ff.width})
             + bw_s;
      lo_y = $signed({{3{rect_ff.top[15]}}, rect_ff.top}) - bw_s;
      hi_y = $signed({{3{rect_ff.top[15]}}, rect_ff.top}) + $signed({7'd0, rect_ff.height})
             + bw_s;
      hit  = (px_s >= lo_x) && (px_s < hi_x) && (py_s >= lo_y) && (py_s < hi_y);
   end

   assign slot = slot_ff;
   assign rect = rect_ff;

endmodule

// ===== rtl/window_stack_pointer_hit_and_drag.sv =====
`timescale 1ns / 1ps
// Top level: window stack as a row of cells, pointer tracking, hit scan, raise and drag.
//
//   channel  direction  handshake                 payload
//   req      in         req_tvalid / req_tready   req_tdata, req_tuser (open flag)
//   rsp      out        rsp_tvalid / rsp_tready   rsp_tdata
//   csr      in/out     APB psel/penable/pready   paddr, pwdata, prdata
//
// One transaction at a time. Open items and pointer reports without a new press
// pass from accept through the drag and result states to the response register. A new
// press scans the cells front to back, one cell a cycle, then bubbles the hit cell up
// one position a cycle. Synchronous active-high reset; no clearing pass.
// A stalled result holds the block in its result state until rsp_tready.
module window_stack_pointer_hit_and_drag #(
   parameter int  WINDOW_SLOTS = 8,
   localparam int SLOT_W       = $clog2(WINDOW_SLOTS),
   localparam int COUNT_W      = $clog2(WINDOW_SLOTS + 1),
   localparam int RSP_FIELDS   = 12 + 12 + COUNT_W + 1 + SLOT_W + 16 + 16 + SLOT_W
                                 + COUNT_W + 1 + SLOT_W,
   localparam int RSP_W        = ((RSP_FIELDS + 7) / 8) * 8
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_tvalid,
   output logic                       req_tready,
   // move_dx[8:0], move_dy[17:9], left_button[18], new_x[34:19], new_y[50:35],
   // new_width[62:51], new_height[74:63], zero fill
   input  logic [wspd_pkg::REQ_W-1:0] req_tdata,
   // action
   input  logic                       req_tuser,
   output logic                       rsp_tvalid,
   input  logic                       rsp_tready,
   // pointer_x_out, pointer_y_out, hit_slot, drag_on, drag_slot_out, dragged_x,
   // dragged_y, top_slot, open_count, open_accepted, opened_slot, zero fill
   output logic [RSP_W-1:0]           rsp_tdata,
   input  logic                       csr_psel,
   input  logic                       csr_penable,
   input  logic                       csr_pwrite,
   input  logic [3:0]                 csr_paddr,
   input  logic [31:0]                csr_pwdata,
   output logic [31:0]                csr_prdata,
   output logic                       csr_pready
);

   // request fields
   logic signed [8:0]  move_dx, move_dy;
   logic               left_button;
   wspd_pkg::rect_type new_rect;

   assign move_dx         = $signed(req_tdata[8:0]);
   assign move_dy         = $signed(req_tdata[17:9]);
   assign left_button     = req_tdata[18];
   assign new_rect.left   = req_tdata[34:19];
   assign new_rect.top    = req_tdata[50:35];
   assign new_rect.width  = req_tdata[62:51];
   assign new_rect.height = req_tdata[74:63];

   // configuration
   logic [12:0] screen_width_ff, screen_height_ff;
   logic [7:0]  title_height_ff;
   logic [3:0]  border_width_ff;
   logic [11:0] limit_x_ff, limit_y_ff;
   logic        csr_wr;
   wspd_pkg::reg_index_type csr_index;

   // control state
   wspd_pkg::state_type state_ff, state_in;
   logic [COUNT_W-1:0]      total_ff;
   logic [11:0]             pointer_x_ff, pointer_y_ff;
   logic                    left_down_ff, drag_active_ff, is_ptr_ff, press_ff;
   logic [SLOT_W-1:0]       drag_slot_ff, top_slot_ff, opened_ff;
   logic [15:0]             grab_dx_ff, grab_dy_ff;
   logic [WINDOW_SLOTS-1:0] scan_ff, bubble_ff, drag_pos_ff;
   logic [COUNT_W-1:0]      hit_ff;
   logic                    accepted_ff;
   logic [15:0]             cap_left_ff, cap_top_ff;
   logic [15:0]             dragged_x_ff, dragged_y_ff;
   logic                    rsp_tvalid_ff;
   logic [RSP_W-1:0]        rsp_tdata_ff;

   // decoded controls
   logic accept, open_room, scan_hit, raise_top, raise_swap, drag_wr, rsp_load, title_hit;
   logic [WINDOW_SLOTS-1:0] top_oh, valid_mask, hit_vec;
   logic [SLOT_W-1:0]       sel_slot;
   wspd_pkg::rect_type      sel_rect;
   logic signed [13:0]      sum_x, sum_y;
   logic [11:0]             next_x, next_y;
   logic [15:0]             drag_left, drag_top;

   // cell row
   logic [SLOT_W-1:0]       slot_arr [WINDOW_SLOTS];
   wspd_pkg::rect_type      rect_arr [WINDOW_SLOTS];
   wspd_pkg::cell_ctl_type  cell_ctl [WINDOW_SLOTS];

   function automatic logic [11:0] screen_limit(input logic [12:0] s);
      logic [12:0] d;
      d = s - 13'd2;
      priority if (s < 13'd2) screen_limit = 12'd0;
      else if (s > 13'd4096) screen_limit = 12'd4094;
      else screen_limit = d[11:0];
   endfunction

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_index  = wspd_pkg::reg_index_type'(csr_paddr[3:2]);

   always_comb begin
      unique case (csr_index)
         wspd_pkg::REG_SCREEN_WIDTH:  csr_prdata = {19'd0, screen_width_ff};
         wspd_pkg::REG_SCREEN_HEIGHT: csr_prdata = {19'd0, screen_height_ff};
         wspd_pkg::REG_TITLE_HEIGHT:  csr_prdata = {24'd0, title_height_ff};
         wspd_pkg::REG_BORDER_WIDTH:  csr_prdata = {28'd0, border_width_ff};
         default:                     csr_prdata = 32'd0;
      endcase
   end

   // occupancy decode
   always_comb begin
      for (int p = 0; p < WINDOW_SLOTS; p++) begin
         top_oh[p]     = (total_ff == COUNT_W'(p + 1));
         valid_mask[p] = (COUNT_W'(p) < total_ff);
      end
   end

   // contents of the cell under the scan token
   always_comb begin
      sel_slot = '0;
      sel_rect = '0;
      for (int p = 0; p < WINDOW_SLOTS; p++) begin
         if (scan_ff[p]) begin
            sel_slot = sel_slot | slot_arr[p];
            sel_rect = sel_rect | rect_arr[p];
         end
      end
   end

   // pointer motion with clamp
   always_comb begin
      sum_x = $signed({2'b00, pointer_x_ff}) + $signed({{5{move_dx[8]}}, move_dx});
      sum_y = $signed({2'b00, pointer_y_ff}) + $signed({{5{move_dy[8]}}, move_dy});
      priority if (sum_x < 14'sd0) next_x = 12'd0;
      else if (sum_x > $signed({2'b00, limit_x_ff})) next_x = limit_x_ff;
      else next_x = sum_x[11:0];
      priority if (sum_y < 14'sd0) next_y = 12'd0;
      else if (sum_y > $signed({2'b00, limit_y_ff})) next_y = limit_y_ff;
      else next_y = sum_y[11:0];
   end

   assign title_hit = $signed({7'd0, pointer_y_ff}) <
                      $signed({{3{cap_top_ff[15]}}, cap_top_ff}) + $signed({11'd0, title_height_ff});
   assign drag_left = {4'd0, pointer_x_ff} - grab_dx_ff;
   assign drag_top  = {4'd0, pointer_y_ff} - grab_dy_ff;
   assign open_room = total_ff < COUNT_W'(WINDOW_SLOTS);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         wspd_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (!req_tuser && left_button && !left_down_ff && (total_ff != '0))
                  state_in = wspd_pkg::ST_SCAN;
               else
                  state_in = wspd_pkg::ST_DRAG;
            end
         end
         wspd_pkg::ST_SCAN: begin
            if (scan_hit) state_in = wspd_pkg::ST_RAISE;
            else if (scan_ff[0]) state_in = wspd_pkg::ST_DRAG;
         end
         wspd_pkg::ST_RAISE: begin
            if (raise_top) state_in = wspd_pkg::ST_DRAG;
         end
         wspd_pkg::ST_DRAG: state_in = wspd_pkg::ST_RESULT;
         wspd_pkg::ST_RESULT: begin
            if (!rsp_tvalid_ff || rsp_tready) state_in = wspd_pkg::ST_IDLE;
         end
         default: state_in = wspd_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_tready = 1'b0;
      scan_hit   = 1'b0;
      raise_top  = 1'b0;
      raise_swap = 1'b0;
      drag_wr    = 1'b0;
      rsp_load   = 1'b0;
      unique case (state_ff)
         wspd_pkg::ST_IDLE:   req_tready = 1'b1;
         wspd_pkg::ST_SCAN:   scan_hit = |(scan_ff & hit_vec);
         wspd_pkg::ST_RAISE: begin
            raise_top  = |(bubble_ff & top_oh);
            raise_swap = !raise_top;
         end
         wspd_pkg::ST_DRAG:   drag_wr = is_ptr_ff & drag_active_ff;
         wspd_pkg::ST_RESULT: rsp_load = !rsp_tvalid_ff || rsp_tready;
         default: ;
      endcase
   end

   assign accept = req_tvalid & req_tready;

   // per-cell controls; a raise swaps the bubble cell with the one above it
   always_comb begin
      for (int p = 0; p < WINDOW_SLOTS; p++) begin
         cell_ctl[p].load       = accept & req_tuser & open_room & (total_ff == COUNT_W'(p));
         cell_ctl[p].take_above = raise_swap & bubble_ff[p];
         cell_ctl[p].take_below = (p > 0) ? (raise_swap & bubble_ff[(p > 0) ? p - 1 : 0])
                                          : 1'b0;
         cell_ctl[p].drag_wr    = drag_wr & drag_pos_ff[p];
      end
   end

   for (genvar p = 0; p < WINDOW_SLOTS; p++) begin : g_cell
      localparam int UP = (p + 1 < WINDOW_SLOTS) ? p + 1 : p;
      localparam int DN = (p > 0) ? p - 1 : p;
      wspd_cell #(.SLOT_W(SLOT_W)) u_cell (
         .clock      (clock),
         .ctl        (cell_ctl[p]),
         .load_slot  (total_ff[SLOT_W-1:0]),
         .load_rect  (new_rect),
         .above_slot (slot_arr[UP]),
         .above_rect (rect_arr[UP]),
         .below_slot (slot_arr[DN]),
         .below_rect (rect_arr[DN]),
         .drag_left  (drag_left),
         .drag_top   (drag_top),
         .px         (pointer_x_ff),
         .py         (pointer_y_ff),
         .border     (border_width_ff),
         .slot       (slot_arr[p]),
         .rect       (rect_arr[p]),
         .hit        (hit_vec[p])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= wspd_pkg::SCREEN_WIDTH_RESET;
         screen_height_ff <= wspd_pkg::SCREEN_HEIGHT_RESET;
         title_height_ff  <= wspd_pkg::TITLE_HEIGHT_RESET;
         border_width_ff  <= wspd_pkg::BORDER_WIDTH_RESET;
         limit_x_ff       <= wspd_pkg::LIMIT_X_RESET;
         limit_y_ff       <= wspd_pkg::LIMIT_Y_RESET;
         state_ff         <= wspd_pkg::ST_IDLE;
         total_ff         <= '0;
         pointer_x_ff     <= wspd_pkg::POINTER_X_RESET;
         pointer_y_ff     <= wspd_pkg::POINTER_Y_RESET;
         left_down_ff     <= 1'b0;
         drag_active_ff   <= 1'b0;
         drag_slot_ff     <= '0;
         grab_dx_ff       <= '0;
         grab_dy_ff       <= '0;
         top_slot_ff      <= '0;
         scan_ff          <= '0;
         bubble_ff        <= '0;
         drag_pos_ff      <= '0;
         rsp_tvalid_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;

         if (csr_wr) begin
            unique case (csr_index)
               wspd_pkg::REG_SCREEN_WIDTH: begin
                  screen_width_ff <= csr_pwdata[12:0];
                  limit_x_ff      <= screen_limit(csr_pwdata[12:0]);
               end
               wspd_pkg::REG_SCREEN_HEIGHT: begin
                  screen_height_ff <= csr_pwdata[12:0];
                  limit_y_ff       <= screen_limit(csr_pwdata[12:0]);
               end
               wspd_pkg::REG_TITLE_HEIGHT: title_height_ff <= csr_pwdata[7:0];
               wspd_pkg::REG_BORDER_WIDTH: border_width_ff <= csr_pwdata[3:0];
               default: ;
            endcase
         end

         if (accept) begin
            if (req_tuser) begin
               if (open_room) begin
                  total_ff    <= total_ff + COUNT_W'(1);
                  top_slot_ff <= total_ff[SLOT_W-1:0];
               end
            end else begin
               pointer_x_ff <= next_x;
               pointer_y_ff <= next_y;
               left_down_ff <= left_button;
               if (!left_button) drag_active_ff <= 1'b0;
            end
            scan_ff <= top_oh;
         end

         if (state_ff == wspd_pkg::ST_SCAN) begin
            if (scan_hit) begin
               top_slot_ff <= sel_slot;
               bubble_ff   <= scan_ff;
            end
            scan_ff <= scan_ff >> 1;
         end

         if (raise_swap) bubble_ff <= bubble_ff << 1;
         if (raise_top && title_hit) begin
            drag_active_ff <= 1'b1;
            drag_slot_ff   <= hit_ff[SLOT_W-1:0];
            drag_pos_ff    <= top_oh;
            grab_dx_ff     <= {4'd0, pointer_x_ff} - cap_left_ff;
            grab_dy_ff     <= {4'd0, pointer_y_ff} - cap_top_ff;
         end

         if (rsp_load) rsp_tvalid_ff <= 1'b1;
         else if (rsp_tready) rsp_tvalid_ff <= 1'b0;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         is_ptr_ff   <= !req_tuser;
         press_ff    <= !req_tuser & left_button & !left_down_ff;
         hit_ff      <= COUNT_W'(WINDOW_SLOTS);
         accepted_ff <= req_tuser & open_room;
         opened_ff   <= (req_tuser & open_room) ? total_ff[SLOT_W-1:0] : '0;
      end
      if (scan_hit) begin
         hit_ff      <= COUNT_W'(sel_slot);
         cap_left_ff <= sel_rect.left;
         cap_top_ff  <= sel_rect.top;
      end
      if (drag_wr) begin
         dragged_x_ff <= drag_left;
         dragged_y_ff <= drag_top;
      end
      if (rsp_load) begin
         rsp_tdata_ff <= RSP_W'({opened_ff, accepted_ff, total_ff, top_slot_ff,
                                 drag_active_ff ? dragged_y_ff : 16'd0,
                                 drag_active_ff ? dragged_x_ff : 16'd0,
                                 drag_active_ff ? drag_slot_ff : {SLOT_W{1'b0}},
                                 drag_active_ff, hit_ff, pointer_y_ff, pointer_x_ff});
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

`ifndef NO_ASSERTIONS
   // a drag only lives while the button is held
   a_drag_held: assert property (@(posedge clock) disable iff (reset)
      drag_active_ff |-> left_down_ff)
      else $error("drag active with button released");

   a_scan_token: assert property (@(posedge clock) disable iff (reset)
      state_ff == wspd_pkg::ST_SCAN |-> $onehot(scan_ff) && ((scan_ff & ~valid_mask) == '0))
      else $error("scan token lost or outside the stack");

   a_bubble: assert property (@(posedge clock) disable iff (reset)
      state_ff == wspd_pkg::ST_RAISE |-> $onehot(bubble_ff) && ((bubble_ff & ~valid_mask) == '0))
      else $error("raise bubble lost or outside the stack");

   a_count: assert property (@(posedge clock) disable iff (reset)
      total_ff <= COUNT_W'(WINDOW_SLOTS))
      else $error("window count beyond slot count");

   // a new press only starts a scan on a pointer report
   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      state_ff != wspd_pkg::ST_SCAN ##1 state_ff == wspd_pkg::ST_SCAN |-> press_ff && is_ptr_ff)
      else $error("scan entered without a new press");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the window stack block: directed and random window/pointer traffic.
module testbench;

   localparam int SLOTS = 8;
   localparam int RSP_BITS = 80;

   typedef struct {
      logic              open;
      logic signed [8:0] dx;
      logic signed [8:0] dy;
      logic              btn;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic [11:0]       nw;
      logic [11:0]       nh;
   } win_event_type;

   typedef struct {
      logic [11:0] px;
      logic [11:0] py;
      logic [3:0]  hit;
      logic        drag_on;
      logic [2:0]  drag_slot;
      logic [15:0] drag_x;
      logic [15:0] drag_y;
      logic [2:0]  top;
      logic [3:0]  count;
      logic        accepted;
      logic [2:0]  opened;
   } desk_status_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid, req_tready, req_tuser;
   logic [wspd_pkg::REQ_W-1:0] req_tdata;
   logic rsp_tvalid, rsp_tready;
   logic [RSP_BITS-1:0] rsp_tdata;
   logic csr_psel, csr_penable, csr_pwrite, csr_pready;
   logic [3:0] csr_paddr;
   logic [31:0] csr_pwdata, csr_prdata;

   window_stack_pointer_hit_and_drag #(.WINDOW_SLOTS(SLOTS)) dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predicted desk state
   int scr_w, scr_h, title_h, border_w;
   int win_left[SLOTS], win_top[SLOTS], win_w[SLOTS], win_h[SLOTS], stack[SLOTS];
   int win_total, ptr_x, ptr_y, drag_idx, grab_x, grab_y;
   bit btn_held, drag_live;

   win_event_type   pending_events[$];
   desk_status_type status_due[$];
   win_event_type   driven_event;
   bit req_taken = 1'b0;
   int events_sent = 0, events_taken = 0, results_checked = 0, error_count = 0;
   int send_idle_pct = 0, recv_stall_pct = 0;

   function automatic int bound(int v, int lo, int hi);
      if (v < lo) v = lo;
      if (v > hi) v = hi;
      return v;
   endfunction

   function automatic int pointer_limit(int s);
      return bound(s, 2, 4096) - 2;
   endfunction

   function automatic int wrap16(int v);
      logic signed [15:0] t;
      t = v[15:0];
      return t;
   endfunction

   function automatic int srand_range(int lo, int hi);
      return lo + int'($urandom_range(hi - lo));
   endfunction

   task automatic apply_window_event(input win_event_type ev, output desk_status_type st);
      int b, hit, s, at, i;
      bit was;
      hit = SLOTS;
      st = '{default: '0};
      if (ev.open) begin
         if (win_total < SLOTS) begin
            s = win_total;
            win_left[s] = ev.nx;
            win_top[s] = ev.ny;
            win_w[s] = ev.nw;
            win_h[s] = ev.nh;
            stack[s] = s;
            win_total = s + 1;
            st.accepted = 1'b1;
            st.opened = s[2:0];
         end
      end else begin
         was = btn_held;
         b = border_w;
         ptr_x = bound(ptr_x + ev.dx, 0, pointer_limit(scr_w));
         ptr_y = bound(ptr_y + ev.dy, 0, pointer_limit(scr_h));
         btn_held = ev.btn;
         if (ev.btn && !was) begin
            // front to back, border counts as part of the window
            for (i = win_total - 1; i >= 0; i--) begin
               s = stack[i];
               if (ptr_x >= win_left[s] - b && ptr_x < win_left[s] + win_w[s] + b &&
                   ptr_y >= win_top[s] - b && ptr_y < win_top[s] + win_h[s] + b) begin
                  hit = s;
                  break;
               end
            end
            if (hit < SLOTS) begin
               at = 0;
               for (i = 0; i < win_total; i++)
                  if (stack[i] == hit) at = i;
               for (i = at; i + 1 < win_total; i++)
                  stack[i] = stack[i + 1];
               stack[win_total - 1] = hit;
               if (ptr_y < win_top[hit] + title_h) begin
                  drag_live = 1'b1;
                  drag_idx = hit;
                  grab_x = wrap16(ptr_x - win_left[hit]);
                  grab_y = wrap16(ptr_y - win_top[hit]);
               end
            end
         end
         if (!ev.btn) drag_live = 1'b0;
         if (drag_live) begin
            win_left[drag_idx] = wrap16(ptr_x - grab_x);
            win_top[drag_idx] = wrap16(ptr_y - grab_y);
         end
      end
      st.px = ptr_x[11:0];
      st.py = ptr_y[11:0];
      st.hit = hit[3:0];
      st.drag_on = drag_live;
      if (drag_live) begin
         st.drag_slot = drag_idx[2:0];
         st.drag_x = win_left[drag_idx][15:0];
         st.drag_y = win_top[drag_idx][15:0];
      end
      if (win_total > 0) st.top = stack[win_total - 1][2:0];
      st.count = win_total[3:0];
   endtask

   task automatic note_error(string msg);
      $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) note_error($sformatf("%s expected %0h got %0h", name, want, got));
   endtask

   // driver: new transaction offered at the falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_taken) begin
            if (pending_events.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               driven_event = pending_events.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= {5'b0, driven_event.nh, driven_event.nw, driven_event.ny,
                             driven_event.nx, driven_event.btn, driven_event.dy,
                             driven_event.dx};
               req_tuser <= driven_event.open;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // monitor: predict on accepted requests, compare accepted results
   always @(posedge clock) begin
      desk_status_type st;
      if (!reset) begin
         req_taken = req_tvalid && req_tready;
         if (req_taken) begin
            apply_window_event(driven_event, st);
            status_due.push_back(st);
            events_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (status_due.size() == 0) begin
               note_error("result transaction with nothing pending");
            end else begin
               st = status_due.pop_front();
               check_field("pointer_x", st.px, rsp_tdata[11:0]);
               check_field("pointer_y", st.py, rsp_tdata[23:12]);
               check_field("hit_slot", st.hit, rsp_tdata[27:24]);
               check_field("drag_on", st.drag_on, rsp_tdata[28]);
               check_field("drag_slot", st.drag_slot, rsp_tdata[31:29]);
               check_field("dragged_x", st.drag_x, rsp_tdata[47:32]);
               check_field("dragged_y", st.drag_y, rsp_tdata[63:48]);
               check_field("top_slot", st.top, rsp_tdata[66:64]);
               check_field("open_count", st.count, rsp_tdata[70:67]);
               check_field("open_accepted", st.accepted, rsp_tdata[71]);
               check_field("opened_slot", st.opened, rsp_tdata[74:72]);
               check_field("fill", 16'd0, rsp_tdata[79:75]);
            end
            results_checked++;
         end
      end
   end

   function automatic win_event_type motion_event(int dx, int dy, bit btn);
      win_event_type ev;
      ev.open = 1'b0;
      ev.dx = dx[8:0];
      ev.dy = dy[8:0];
      ev.btn = btn;
      ev.nx = 16'($urandom);
      ev.ny = 16'($urandom);
      ev.nw = 12'($urandom);
      ev.nh = 12'($urandom);
      return ev;
   endfunction

   function automatic win_event_type open_event(int x, int y, int w, int h);
      win_event_type ev;
      ev.open = 1'b1;
      ev.dx = 9'($urandom);
      ev.dy = 9'($urandom);
      ev.btn = 1'($urandom);
      ev.nx = x[15:0];
      ev.ny = y[15:0];
      ev.nw = w[11:0];
      ev.nh = h[11:0];
      return ev;
   endfunction

   // one transaction at a time so the aim below sees the current pointer
   task automatic send_event(win_event_type ev);
      pending_events.push_back(ev);
      events_sent++;
      wait (events_taken == events_sent);
   endtask

   task automatic move_pointer_to(int tx, int ty);
      int dx, dy, px0, py0, steps;
      for (steps = 0; steps < 32; steps++) begin
         dx = bound(tx - ptr_x, -256, 255);
         dy = bound(ty - ptr_y, -256, 255);
         if (dx == 0 && dy == 0) break;
         px0 = ptr_x;
         py0 = ptr_y;
         send_event(motion_event(dx, dy, 1'b0));
         if (ptr_x == px0 && ptr_y == py0) break;
      end
   endtask

   // aim at a window (title bar most of the time), press, drag a little, usually release
   task automatic press_gesture();
      int s, tx, ty, b, span, k, i;
      b = border_w;
      if (win_total == 0) begin
         tx = srand_range(0, pointer_limit(scr_w));
         ty = srand_range(0, pointer_limit(scr_h));
      end else begin
         s = stack[$urandom_range(win_total - 1)];
         span = win_w[s] + 2 * b - 1;
         tx = win_left[s] - b + int'($urandom_range(span < 0 ? 0 : span));
         if ($urandom_range(99) < 60 && title_h > 0) begin
            ty = win_top[s] + int'($urandom_range(title_h - 1));
         end else begin
            span = win_h[s] + 2 * b - 1;
            ty = win_top[s] - b + int'($urandom_range(span < 0 ? 0 : span));
         end
      end
      move_pointer_to(tx, ty);
      send_event(motion_event(0, 0, 1'b1));
      k = $urandom_range(5);
      for (i = 0; i < k; i++)
         send_event(motion_event(srand_range(-80, 80), srand_range(-80, 80), 1'b1));
      if ($urandom_range(99) < 70) send_event(motion_event(0, 0, 1'b0));
   endtask

   task automatic write_register(wspd_pkg::reg_index_type idx, int value);
      logic [31:0] pw;
      pw = $urandom;
      case (idx)
         wspd_pkg::REG_SCREEN_WIDTH:  pw[12:0] = value[12:0];
         wspd_pkg::REG_SCREEN_HEIGHT: pw[12:0] = value[12:0];
         wspd_pkg::REG_TITLE_HEIGHT:  pw[7:0] = value[7:0];
         wspd_pkg::REG_BORDER_WIDTH:  pw[3:0] = value[3:0];
      endcase
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {idx, 2'b00};
      csr_pwdata <= pw;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      case (idx)
         wspd_pkg::REG_SCREEN_WIDTH:  scr_w = pw[12:0];
         wspd_pkg::REG_SCREEN_HEIGHT: scr_h = pw[12:0];
         wspd_pkg::REG_TITLE_HEIGHT:  title_h = pw[7:0];
         wspd_pkg::REG_BORDER_WIDTH:  border_w = pw[3:0];
      endcase
   endtask

   task automatic set_geometry(int w, int h, int t, int b);
      write_register(wspd_pkg::REG_SCREEN_WIDTH, w);
      write_register(wspd_pkg::REG_SCREEN_HEIGHT, h);
      write_register(wspd_pkg::REG_TITLE_HEIGHT, t);
      write_register(wspd_pkg::REG_BORDER_WIDTH, b);
   endtask

   initial begin
      int ph, r, goal;
      int quota[6] = '{220, 80, 170, 170, 180, 180};
      int idle_send[6] = '{0, 45, 0, 37, 45, 37};
      int idle_recv[6] = '{0, 0, 45, 37, 0, 37};

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;

      scr_w = wspd_pkg::SCREEN_WIDTH_RESET;
      scr_h = wspd_pkg::SCREEN_HEIGHT_RESET;
      title_h = wspd_pkg::TITLE_HEIGHT_RESET;
      border_w = wspd_pkg::BORDER_WIDTH_RESET;
      ptr_x = wspd_pkg::POINTER_X_RESET;
      ptr_y = wspd_pkg::POINTER_Y_RESET;
      win_total = 0;
      btn_held = 1'b0;
      drag_live = 1'b0;
      drag_idx = 0;
      grab_x = 0;
      grab_y = 0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (ph = 0; ph < 6; ph++) begin
         // registers change only with the block idle
         wait (results_checked == events_sent);
         case (ph)
            1: set_geometry(0, 1, 0, 0);
            2: set_geometry(8191, 4096, 255, 15);
            3: set_geometry(4097, 3, 1, 7);
            4: set_geometry(srand_range(2, 4096), srand_range(2, 4096),
                            $urandom_range(255), $urandom_range(15));
            5: set_geometry(1024, 768, 26, 2);
            default: ;
         endcase
         send_idle_pct = idle_send[ph];
         recv_stall_pct = idle_recv[ph];

         if (ph == 0) begin
            send_event(motion_event(0, 0, 1'b0));
            send_event(motion_event(0, 0, 1'b1));     // press on an empty desk
            send_event(motion_event(0, 0, 1'b0));
            send_event(open_event(-32768, -32768, 4095, 4095));
            send_event(open_event(32767, 32767, 0, 0));
            send_event(open_event(400, 300, 200, 150));
            send_event(open_event(500, 320, 0, 0));
            repeat (3) send_event(motion_event(-256, -256, 1'b0));
            move_pointer_to(500, 320);
            send_event(motion_event(0, 0, 1'b1));     // grab zero-size window by its border
            send_event(motion_event(255, -256, 1'b1));
            send_event(motion_event(0, 0, 1'b0));
            move_pointer_to(450, 400);
            send_event(motion_event(0, 0, 1'b1));     // body press: raise only
            send_event(motion_event(0, 0, 1'b0));
            move_pointer_to(100, 100);
            send_event(motion_event(0, 0, 1'b1));     // miss
            send_event(motion_event(0, 0, 1'b0));
            repeat (4) send_event(motion_event(255, 255, 1'b0));
         end

         goal = events_sent + quota[ph];
         while (events_sent < goal) begin
            r = $urandom_range(99);
            if (r < 8) begin
               if ($urandom_range(1))
                  send_event(open_event(srand_range(-50, pointer_limit(scr_w)),
                                        srand_range(-50, pointer_limit(scr_h)),
                                        $urandom_range(400), $urandom_range(300)));
               else
                  send_event(open_event(srand_range(-32768, 32767), srand_range(-32768, 32767),
                                        $urandom_range(4095), $urandom_range(4095)));
            end else if (r < 22) begin
               send_event(motion_event(srand_range(-256, 255), srand_range(-256, 255),
                                       $urandom_range(1)));
            end else begin
               press_gesture();
            end
         end
      end

      wait (results_checked == events_sent);
      repeat (48) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== window_stack_pointer_hit_and_drag.f =====
rtl/wspd_pkg.sv
rtl/wspd_cell.sv
rtl/window_stack_pointer_hit_and_drag.sv
bench/testbench.sv
